// File: src/cli_pkg.sv
// Shared types, field widths and result codes of the conflict list interning core.
`default_nettype none
package cli_pkg;

    localparam int PRI_W  = 16;
    localparam int ACT_W  = 16;
    localparam int IDX_W  = 12;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_FOUND = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMAP = 3'd3;
    localparam logic [STAT_W-1:0] ST_SHORT = 3'd4;

    localparam logic REQ_MAP   = 1'b0;
    localparam logic REQ_REMAP = 1'b1;

    typedef struct packed {
        logic              load_en;
        logic              head_latch;
        logic              elem_latch;
        logic              next_elem;
        logic              j_clr;
        logic              j_inc;
        logic              wr_step;
        logic              commit;
        logic              remap_step;
        logic              res_set;
        logic [STAT_W-1:0] res_code;
        logic              out_load;
    } cli_cmd_t;

    typedef struct packed {
        logic list_done;
        logic is_remap;
        logic too_short;
        logic k_end;
        logic j_end;
        logic p_oob;
        logic cmp_eq;
        logic full;
        logic out_free;
    } cli_stat_t;

endpackage
`default_nettype wire

// File: src/conflict_list_interning_core.sv
// Top level of the conflict list interning core: sequencer plus datapath.
//
// Cells (priority, action) arrive one request per cycle while the core is idle and are
// buffered twice: in arrival order and, by a parallel stable insertion, in ascending
// priority order; the bucket hash (sum of actions, low bits) accumulates on the fly.
// The request carrying last_cell closes the list and raises in_stall until the result
// has moved to the output register. A short list is reported at dispatch, and a remap
// list overwrites the store from its target index in arrival order. A map list fetches
// the bucket head, then per chain element latches its start and next link and compares
// store words (one registered read of the action store each; a word at or past the fill
// point ends the compare), and finds the chain end; a miss then appends the run, or
// reports a full store. A final state hands the result over, and a stalled output
// register holds the core in that state.
// Results wait in an output register, so a list can load while the last one is unread.
// BUCKETS must be a power of two. The chain heads carry one valid flop per bucket, so no
// clearing pass is needed after reset.
`default_nettype none
module conflict_list_interning_core #(
    parameter int MAX_CELLS    = 16,
    parameter int BUCKETS      = 256,
    parameter int STORE_DEPTH  = 4096,
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               req_type,
    input  wire logic        [cli_pkg::PRI_W-1:0]   cell_priority,
    input  wire logic signed [cli_pkg::ACT_W-1:0]   cell_action,
    input  wire logic        [cli_pkg::IDX_W-1:0]   target_index,
    input  wire logic                               last_cell,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic             [cli_pkg::IDX_W-1:0]   list_start,
    output logic             [cli_pkg::STAT_W-1:0]  status
);

    cli_pkg::cli_cmd_t  cmd;
    cli_pkg::cli_stat_t st;

    // hold off requests whenever the sequencer is not loading cells
    assign in_stall = !cmd.load_en;

    cli_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    cli_dp #(
        .MAX_CELLS    (MAX_CELLS),
        .BUCKETS      (BUCKETS),
        .STORE_DEPTH  (STORE_DEPTH),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .in_valid      (in_valid),
        .req_type      (req_type),
        .cell_priority (cell_priority),
        .cell_action   (cell_action),
        .target_index  (target_index),
        .last_cell     (last_cell),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .list_start    (list_start),
        .status        (status)
    );

endmodule
`default_nettype wire

// File: src/cli_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module cli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: src/cli_ctrl.sv
// Sequencer of the interning core: list dispatch, chain walk, append, remap and result handoff.
`default_nettype none
module cli_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cli_pkg::cli_stat_t  st,
    output cli_pkg::cli_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_HEAD,
        S_ELEM,
        S_ELEMD,
        S_CADDR,
        S_CDATA,
        S_FULLCHK,
        S_WRITE,
        S_REMAP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_en = 1'b1;
                if (st.list_done)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.is_remap)
                begin
                    cmd.j_clr  = 1'b1;
                    state_next = S_REMAP;
                end
                else if (st.too_short)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = cli_pkg::ST_SHORT;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head_latch = 1'b1;
                state_next     = S_ELEM;
            end
            S_ELEM:
            begin
                state_next = st.k_end ? S_FULLCHK : S_ELEMD;
            end
            S_ELEMD:
            begin
                cmd.elem_latch = 1'b1;
                cmd.j_clr      = 1'b1;
                state_next     = S_CADDR;
            end
            S_CADDR:
            begin
                if (st.p_oob)
                begin
                    if (st.j_end)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = cli_pkg::ST_FOUND;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.next_elem = 1'b1;
                        state_next    = S_ELEM;
                    end
                end
                else
                begin
                    state_next = S_CDATA;
                end
            end
            S_CDATA:
            begin
                if (st.cmp_eq && st.j_end)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = cli_pkg::ST_FOUND;
                    state_next   = S_DONE;
                end
                else if (st.cmp_eq)
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_CADDR;
                end
                else
                begin
                    cmd.next_elem = 1'b1;
                    state_next    = S_ELEM;
                end
            end
            S_FULLCHK:
            begin
                if (st.full)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = cli_pkg::ST_FULL;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.j_clr  = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (st.j_end)
                begin
                    cmd.commit   = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_code = cli_pkg::ST_NEW;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.j_inc = 1'b1;
                end
            end
            S_REMAP:
            begin
                if (st.j_end)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = cli_pkg::ST_REMAP;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.remap_step = 1'b1;
                    cmd.j_inc      = 1'b1;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: src/cli_dp.sv
// Datapath: cell buffers, running hash, store and chain memories, indices and result registers.
`default_nettype none
module cli_dp #(
    parameter int MAX_CELLS    = 16,
    parameter int BUCKETS      = 256,
    parameter int STORE_DEPTH  = 4096,
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cli_pkg::cli_cmd_t                  cmd,
    output cli_pkg::cli_stat_t                      st,
    input  wire logic                               in_valid,
    input  wire logic                               req_type,
    input  wire logic        [cli_pkg::PRI_W-1:0]   cell_priority,
    input  wire logic signed [cli_pkg::ACT_W-1:0]   cell_action,
    input  wire logic        [cli_pkg::IDX_W-1:0]   target_index,
    input  wire logic                               last_cell,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic             [cli_pkg::IDX_W-1:0]   list_start,
    output logic             [cli_pkg::STAT_W-1:0]  status
);

    localparam int CNW = $clog2(MAX_CELLS + 1);
    localparam int CIW = $clog2(MAX_CELLS);
    localparam int HB  = $clog2(BUCKETS);
    localparam int SA  = $clog2(STORE_DEPTH);
    localparam int PW  = ((SA > cli_pkg::IDX_W) ? SA : cli_pkg::IDX_W) + 1;
    localparam int EA  = $clog2(MAX_ELEMENTS);
    localparam int EW  = $clog2(MAX_ELEMENTS + 1);
    localparam int AW  = cli_pkg::ACT_W;

    // cell buffers: arrival order for remap, priority order for map
    logic [AW-1:0]             arr_act_reg [MAX_CELLS];
    logic [cli_pkg::PRI_W-1:0] srt_pri_reg [MAX_CELLS];
    logic [cli_pkg::PRI_W-1:0] srt_pri_next [MAX_CELLS];
    logic [AW-1:0]             srt_act_reg [MAX_CELLS];
    logic [AW-1:0]             srt_act_next [MAX_CELLS];
    logic [cli_pkg::PRI_W-1:0] shp_pri [MAX_CELLS];
    logic [AW-1:0]             shp_act [MAX_CELLS];
    logic [MAX_CELLS-1:0]      gt;
    logic [MAX_CELLS-1:0]      gtp;

    logic [CNW-1:0]            cnt_reg;
    logic [CNW-1:0]            cnt_inc;
    logic [CNW-1:0]            n_reg;
    logic [HB-1:0]             sum_reg;
    logic [HB-1:0]             sum_next;
    logic [HB-1:0]             h_reg;
    logic                      req_reg;
    logic [cli_pkg::IDX_W-1:0] tgt_reg;
    logic [CNW-1:0]            j_reg;
    logic [CIW-1:0]            jidx;
    logic [EW-1:0]             k_reg;
    logic [EW-1:0]             kn_reg;
    logic [EW-1:0]             hd_reg;
    logic [SA-1:0]             start_reg;
    logic [PW-1:0]             fill_reg;
    logic [EW-1:0]             ec_reg;
    logic [BUCKETS-1:0]        bvalid_reg;
    logic [cli_pkg::IDX_W-1:0] res_start_reg;
    logic [cli_pkg::STAT_W-1:0] res_status_reg;
    logic                      out_valid_reg;
    logic [cli_pkg::IDX_W-1:0] list_start_reg;
    logic [cli_pkg::STAT_W-1:0] status_reg;

    logic                      take;
    logic                      store_ok;
    logic [PW-1:0]             p_cmp;
    logic [PW-1:0]             p_wr;
    logic [PW-1:0]             p_rm;
    logic [PW-1:0]             start_ext;
    logic                      rm_ok;
    logic [AW-1:0]             cmp_ref;
    logic [cli_pkg::IDX_W-1:0] res_start_sel;
    logic [EW-1:0]             head_val;

    logic                      st_we;
    logic [SA-1:0]             st_waddr;
    logic [AW-1:0]             st_wdata;
    logic [AW-1:0]             st_rdata;
    logic [EW-1:0]             bh_rdata;
    logic [EW-1:0]             en_rdata;
    logic [SA-1:0]             es_rdata;

    assign take     = in_valid && cmd.load_en;
    assign store_ok = cnt_reg < CNW'(MAX_CELLS);
    assign cnt_inc  = store_ok ? cnt_reg + CNW'(1) : cnt_reg;
    assign sum_next = store_ok ? sum_reg + cell_action[HB-1:0] : sum_reg;
    assign jidx     = j_reg[CIW-1:0];

    // stable insertion: entries with a strictly larger priority move up one place
    always_comb
    begin
        gtp[0]     = 1'b0;
        shp_pri[0] = '0;
        shp_act[0] = '0;
        for (int i = 0; i < MAX_CELLS; i++)
        begin
            gt[i] = (CNW'(i) < cnt_reg) && (srt_pri_reg[i] > cell_priority);
        end
        for (int i = 1; i < MAX_CELLS; i++)
        begin
            gtp[i]     = gt[i-1];
            shp_pri[i] = srt_pri_reg[i-1];
            shp_act[i] = srt_act_reg[i-1];
        end
        for (int i = 0; i < MAX_CELLS; i++)
        begin
            srt_pri_next[i] = srt_pri_reg[i];
            srt_act_next[i] = srt_act_reg[i];
            if (take && store_ok && (CNW'(i) <= cnt_reg) && !((CNW'(i) < cnt_reg) && !gt[i]))
            begin
                if (gtp[i])
                begin
                    srt_pri_next[i] = shp_pri[i];
                    srt_act_next[i] = shp_act[i];
                end
                else
                begin
                    srt_pri_next[i] = cell_priority;
                    srt_act_next[i] = cell_action;
                end
            end
        end
    end

    assign start_ext = PW'(start_reg);
    assign p_cmp     = start_ext + PW'(j_reg);
    assign p_wr      = fill_reg + PW'(j_reg);
    assign p_rm      = PW'(tgt_reg) + PW'(j_reg);
    assign rm_ok     = (p_rm < fill_reg) && (p_rm < PW'(STORE_DEPTH));
    assign cmp_ref   = st.j_end ? '0 : srt_act_reg[jidx];
    assign head_val  = bvalid_reg[h_reg] ? bh_rdata : EW'(MAX_ELEMENTS);

    assign st.list_done = take && last_cell;
    assign st.is_remap  = req_reg == cli_pkg::REQ_REMAP;
    assign st.too_short = n_reg < CNW'(2);
    assign st.k_end     = k_reg >= ec_reg;
    assign st.j_end     = j_reg == n_reg;
    assign st.p_oob     = (p_cmp >= fill_reg) || (p_cmp >= PW'(STORE_DEPTH));
    assign st.cmp_eq    = st_rdata == cmp_ref;
    assign st.full      = (ec_reg >= EW'(MAX_ELEMENTS))
                       || ((fill_reg + PW'(n_reg) + PW'(1)) > PW'(STORE_DEPTH));
    assign st.out_free  = !out_valid_reg || !out_stall;

    // store write port: append step or remap overwrite
    assign st_we    = cmd.wr_step || (cmd.remap_step && rm_ok);
    assign st_waddr = cmd.wr_step ? p_wr[SA-1:0] : p_rm[SA-1:0];
    assign st_wdata = cmd.wr_step ? cmp_ref : arr_act_reg[jidx];

    cli_ram #(.WIDTH(AW), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (p_cmp[SA-1:0]),
        .rdata (st_rdata)
    );

    cli_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (h_reg),
        .wdata (ec_reg),
        .raddr (h_reg),
        .rdata (bh_rdata)
    );

    cli_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_enext (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ec_reg[EA-1:0]),
        .wdata (hd_reg),
        .raddr (k_reg[EA-1:0]),
        .rdata (en_rdata)
    );

    cli_ram #(.WIDTH(SA), .DEPTH(MAX_ELEMENTS)) u_estart (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (ec_reg[EA-1:0]),
        .wdata (fill_reg[SA-1:0]),
        .raddr (k_reg[EA-1:0]),
        .rdata (es_rdata)
    );

    always_comb
    begin
        case (cmd.res_code)
            cli_pkg::ST_FOUND: res_start_sel = start_ext[cli_pkg::IDX_W-1:0];
            cli_pkg::ST_NEW:   res_start_sel = fill_reg[cli_pkg::IDX_W-1:0];
            cli_pkg::ST_REMAP: res_start_sel = tgt_reg;
            default:           res_start_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sum_reg       <= '0;
            fill_reg      <= PW'(1);
            ec_reg        <= '0;
            bvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg <= last_cell ? '0 : cnt_inc;
                sum_reg <= last_cell ? '0 : sum_next;
            end
            if (cmd.commit)
            begin
                fill_reg          <= fill_reg + PW'(n_reg) + PW'(1);
                ec_reg            <= ec_reg + EW'(1);
                bvalid_reg[h_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store_ok)
        begin
            arr_act_reg[cnt_reg[CIW-1:0]] <= cell_action;
        end
        srt_pri_reg <= srt_pri_next;
        srt_act_reg <= srt_act_next;
        if (take && last_cell)
        begin
            n_reg   <= cnt_inc;
            h_reg   <= sum_next;
            req_reg <= req_type;
            tgt_reg <= target_index;
        end
        if (cmd.j_clr)
        begin
            j_reg <= '0;
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + CNW'(1);
        end
        if (cmd.head_latch)
        begin
            k_reg  <= head_val;
            hd_reg <= head_val;
        end
        else if (cmd.next_elem)
        begin
            k_reg <= kn_reg;
        end
        if (cmd.elem_latch)
        begin
            start_reg <= es_rdata;
            kn_reg    <= en_rdata;
        end
        if (cmd.res_set)
        begin
            res_start_reg  <= res_start_sel;
            res_status_reg <= cmd.res_code;
        end
        if (cmd.out_load)
        begin
            list_start_reg <= res_start_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign list_start = list_start_reg;
    assign status     = status_reg;

endmodule
`default_nettype wire

// File: src/cli_checker.sv
// Port-level assertions of the interning core and the bind that attaches them.
`default_nettype none
module cli_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              last_cell,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [cli_pkg::IDX_W-1:0]         list_start,
    input wire logic [cli_pkg::STAT_W-1:0]        status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(list_start) && $stable(status))
        else $error("stalled result changed");

    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_cell |=> in_stall)
        else $error("request taken right after a closing cell");

    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while loading cells");

    a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cli_pkg::ST_FULL || status == cli_pkg::ST_SHORT)
        |-> list_start == '0)
        else $error("nonzero start on full or short status");

endmodule

bind conflict_list_interning_core cli_checker u_cli_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .last_cell     (last_cell),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .list_start    (list_start),
    .status        (status)
);
`default_nettype wire
